@@ rtl/qnl_pkg.sv @@
// ---------------------------------------------------------------------------
// qnl_pkg - shared constants for the quaternion nlerp datapath
// Holds the lane count that the normalizer and the top level both split on.
// ---------------------------------------------------------------------------
package qnl_pkg;

    // one lane per quaternion component: w, x, y, z
    localparam int unsigned QNL_LANES = 4;

endpackage

@@ rtl/quaternion_nlerp.sv @@
// ---------------------------------------------------------------------------
// quaternion_nlerp - normalized linear blend of two quaternions
// Normalizes a and b, flips b onto the short arc, blends by t and
// normalizes the blend. Components signed Q2.14, blend unsigned Q1.14.
//
//  channel   dir  fields (low bit first)
//  s (in)    in   tdata: a_w a_x a_y a_z b_w b_x b_y b_z blend_factor
//  m (out)   out  tdata: r_w r_x r_y r_z ; tuser: zero_result
//
// One request per cycle when the output side keeps up. Latency is set
// by the two square root and divider pipelines in series. Reset clears
// all valid bits only. A stalled output holds the whole pipeline and
// drops o_s_tready.
// ---------------------------------------------------------------------------
module quaternion_nlerp #(
    parameter int FRAC_BITS  = 14,
    parameter int COMP_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend_factor, zero pad
    input  logic [((8*COMP_WIDTH+FRAC_BITS+8)/8)*8-1:0] i_s_tdata,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    // r_w, r_x, r_y, r_z, zero pad
    output logic [((4*COMP_WIDTH+7)/8)*8-1:0]         o_m_tdata,
    // zero_result
    output logic                                      o_m_tuser,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready
);
    import qnl_pkg::*;

    localparam int W     = COMP_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int T_W   = F + 1;
    localparam int N_W   = F + 2;
    localparam int P_W   = 2 * F + 2;
    localparam int D_W   = 2 * N_W;
    localparam int OTD_W = ((4*COMP_WIDTH+7)/8)*8;
    localparam int SAT_W = (N_W > W) ? N_W : W;
    localparam logic [T_W-1:0] ONE = T_W'(1) << F;
    localparam logic signed [SAT_W-1:0] MAXV = {{(SAT_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] MINV = {{(SAT_W-W+1){1'b1}}, {(W-1){1'b0}}};

    logic w_en;
    logic r_out_valid;

    // whole pipeline moves when the output register is free or drained
    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    // unpack request, clamp blend
    logic signed [W-1:0] w_a [QNL_LANES];
    logic signed [W-1:0] w_b [QNL_LANES];
    logic [T_W-1:0]      w_blend;
    logic [T_W-1:0]      w_t;
    logic [T_W-1:0]      w_om;

    always_comb begin
        for (int l = 0; l < QNL_LANES; l++) begin
            w_a[l] = i_s_tdata[l*W +: W];
            w_b[l] = i_s_tdata[(QNL_LANES+l)*W +: W];
        end
        w_blend = i_s_tdata[2*QNL_LANES*W +: T_W];
        w_t     = (w_blend > ONE) ? ONE : w_blend;
        w_om    = ONE - w_t;
    end

    // normalize both inputs side by side; t rides with a, 1-t with b
    logic                  w_a_vld;
    logic                  w_b_vld;
    logic signed [N_W-1:0] w_na [QNL_LANES];
    logic signed [N_W-1:0] w_nb [QNL_LANES];
    logic                  w_a_zero;
    logic                  w_b_zero;
    logic [T_W-1:0]        w_a_t;
    logic [T_W-1:0]        w_b_om;

    qnl_norm #(
        .V_W   (W),
        .PRE   (F),
        .F     (F),
        .PAY_W (T_W)
    ) u_norm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_v     (w_a),
        .i_pay   (w_t),
        .o_valid (w_a_vld),
        .o_n     (w_na),
        .o_zero  (w_a_zero),
        .o_pay   (w_a_t)
    );

    qnl_norm #(
        .V_W   (W),
        .PRE   (F),
        .F     (F),
        .PAY_W (T_W)
    ) u_norm_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_v     (w_b),
        .i_pay   (w_om),
        .o_valid (w_b_vld),
        .o_n     (w_nb),
        .o_zero  (w_b_zero),
        .o_pay   (w_b_om)
    );

    // stage D: per-lane products for dot and blend
    logic signed [N_W+T_W:0] w_pa [QNL_LANES];
    logic signed [N_W+T_W:0] w_pb [QNL_LANES];
    logic signed [D_W-1:0]   w_pd [QNL_LANES];
    logic signed [P_W-1:0]   r_pa [QNL_LANES];
    logic signed [P_W-1:0]   r_pb [QNL_LANES];
    logic signed [D_W-1:0]   r_pd [QNL_LANES];
    logic                    r_d_vld;

    always_comb begin
        for (int l = 0; l < QNL_LANES; l++) begin
            w_pa[l] = w_na[l] * $signed({1'b0, w_b_om});
            w_pb[l] = w_nb[l] * $signed({1'b0, w_a_t});
            w_pd[l] = w_na[l] * w_nb[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < QNL_LANES; l++) begin
                r_pa[l] <= w_pa[l][P_W-1:0];
                r_pb[l] <= w_pb[l][P_W-1:0];
                r_pd[l] <= w_pd[l];
            end
        end
    end

    // stage E: sign of the dot product
    logic signed [D_W-1:0] w_dot;
    logic                  r_neg;
    logic signed [P_W-1:0] r_pa_e [QNL_LANES];
    logic signed [P_W-1:0] r_pb_e [QNL_LANES];
    logic                  r_e_vld;

    assign w_dot = r_pd[0] + r_pd[1] + r_pd[2] + r_pd[3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg  <= w_dot[D_W-1];
            r_pa_e <= r_pa;
            r_pb_e <= r_pb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_d_vld <= w_a_vld;
            r_e_vld <= r_d_vld;
        end
    end

    // blend, taking b negated for the short arc
    logic signed [P_W-1:0] w_r [QNL_LANES];

    always_comb begin
        for (int l = 0; l < QNL_LANES; l++) begin
            w_r[l] = r_neg ? (r_pa_e[l] - r_pb_e[l]) : (r_pa_e[l] + r_pb_e[l]);
        end
    end

    logic                  w_r_vld;
    logic signed [N_W-1:0] w_rn [QNL_LANES];
    logic                  w_r_zero;

    qnl_norm #(
        .V_W   (P_W),
        .PRE   (0),
        .F     (F),
        .PAY_W (1)
    ) u_norm_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e_vld),
        .i_v     (w_r),
        .i_pay   (r_neg),
        .o_valid (w_r_vld),
        .o_n     (w_rn),
        .o_zero  (w_r_zero),
        .o_pay   ()
    );

    // saturate to the component width
    logic signed [SAT_W-1:0] w_ext [QNL_LANES];
    logic [4*W-1:0]          w_res;

    always_comb begin
        w_res = '0;
        for (int l = 0; l < QNL_LANES; l++) begin
            w_ext[l] = SAT_W'(w_rn[l]);
            if (w_ext[l] > MAXV) begin
                w_ext[l] = MAXV;
            end else if (w_ext[l] < MINV) begin
                w_ext[l] = MINV;
            end
            w_res[l*W +: W] = w_ext[l][W-1:0];
        end
    end

    // output register
    logic [4*W-1:0] r_out_data;
    logic           r_out_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= w_res;
            r_out_zero <= w_r_zero;
        end
    end

    assign o_m_tdata  = OTD_W'(r_out_data);
    assign o_m_tuser  = r_out_zero;
    assign o_m_tvalid = r_out_valid;

    // both input normalizers stay aligned
    a_norm_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_a_vld == w_b_vld)
        else $error("quaternion_nlerp: input normalizers out of step");

    // two zero-length inputs must give a zero dot product term in lane 0
    a_in_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_a_vld && w_a_zero && w_b_zero) |=> (r_d_vld && (r_pd[0] == '0)))
        else $error("quaternion_nlerp: zero inputs gave nonzero products");

    // zero flag goes with all-zero components, nonzero otherwise
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zero) |-> (r_out_data == '0))
        else $error("quaternion_nlerp: zero result with nonzero data");

    a_nonzero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_zero) |-> (r_out_data != '0))
        else $error("quaternion_nlerp: nonzero result with zero data");

endmodule

@@ rtl/qnl_isqrt.sv @@
// ---------------------------------------------------------------------------
// qnl_isqrt - pipelined integer square root
// Digit-by-digit restoring square root, one result bit per stage, with a
// side payload that rides along. Advances only when i_en is high.
// ---------------------------------------------------------------------------
module qnl_isqrt #(
    parameter int IN_W  = 62,
    parameter int PAY_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [IN_W-1:0]       i_rad,
    input  logic [PAY_W-1:0]      i_pay,
    output logic                  o_valid,
    output logic [IN_W/2-1:0]     o_root,
    output logic [PAY_W-1:0]      o_pay
);
    import qnl_pkg::*;

    localparam int RT_W  = IN_W / 2;
    localparam int REM_W = RT_W + 3;

    logic [REM_W-1:0] r_rem  [RT_W];
    logic [RT_W-1:0]  r_root [RT_W];
    logic [IN_W-1:0]  r_rad  [RT_W];
    logic [PAY_W-1:0] r_pay  [RT_W];
    logic             r_vld  [RT_W];

    for (genvar s = 0; s < RT_W; s++) begin : g_stg
        logic [REM_W-1:0] w_rem_in;
        logic [RT_W-1:0]  w_root_in;
        logic [IN_W-1:0]  w_rad_in;
        logic [PAY_W-1:0] w_pay_in;
        logic             w_vld_in;
        logic [REM_W-1:0] w_cur;
        logic [REM_W-1:0] w_trial;
        logic             w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
            assign w_pay_in  = i_pay;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in  = r_rad[s-1];
            assign w_pay_in  = r_pay[s-1];
            assign w_vld_in  = r_vld[s-1];
        end

        // bring down the next radicand pair and try root*4+1
        assign w_cur   = {w_rem_in[REM_W-3:0], w_rad_in[IN_W-1 -: 2]};
        assign w_trial = {1'b0, w_root_in, 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? (w_cur - w_trial) : w_cur;
                r_root[s] <= {w_root_in[RT_W-2:0], w_ge};
                r_rad[s]  <= {w_rad_in[IN_W-3:0], 2'b00};
                r_pay[s]  <= w_pay_in;
            end
        end
    end

    assign o_valid = r_vld[RT_W-1];
    assign o_root  = r_root[RT_W-1];
    assign o_pay   = r_pay[RT_W-1];

endmodule

@@ rtl/qnl_div.sv @@
// ---------------------------------------------------------------------------
// qnl_div - pipelined restoring divider
// One quotient bit per stage. The numerator must be below den * 2^Q_W, so
// the quotient fits Q_W bits. A side payload rides along.
// ---------------------------------------------------------------------------
module qnl_div #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 31,
    parameter int Q_W   = 15,
    parameter int PAY_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quo,
    output logic [PAY_W-1:0] o_pay
);
    import qnl_pkg::*;

    localparam int R_W = DEN_W + 1;

    logic [NUM_W-1:0] w_top;
    assign w_top = i_num >> Q_W;

    logic [R_W-1:0]   r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_lo  [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];
    logic [PAY_W-1:0] r_pay [Q_W];
    logic             r_vld [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stg
        logic [R_W-1:0]   w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [Q_W-1:0]   w_lo_in;
        logic [Q_W-1:0]   w_quo_in;
        logic [PAY_W-1:0] w_pay_in;
        logic             w_vld_in;
        logic [R_W-1:0]   w_cur;
        logic             w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in = w_top[R_W-1:0];
            assign w_den_in = i_den;
            assign w_lo_in  = i_num[Q_W-1:0];
            assign w_quo_in = '0;
            assign w_pay_in = i_pay;
            assign w_vld_in = i_valid;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_lo_in  = r_lo[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_pay_in = r_pay[s-1];
            assign w_vld_in = r_vld[s-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign w_cur = {w_rem_in[DEN_W-1:0], w_lo_in[Q_W-1]};
        assign w_ge  = (w_cur >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? (w_cur - {1'b0, w_den_in}) : w_cur;
                r_den[s] <= w_den_in;
                r_lo[s]  <= {w_lo_in[Q_W-2:0], 1'b0};
                r_quo[s] <= {w_quo_in[Q_W-2:0], w_ge};
                r_pay[s] <= w_pay_in;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_pay   = r_pay[Q_W-1];

endmodule

@@ rtl/qnl_norm.sv @@
// ---------------------------------------------------------------------------
// qnl_norm - quaternion normalizer
// Squares the four components in parallel lanes, sums them, takes the
// square root and divides each component by the magnitude with rounding
// half away from zero. Output is signed with F fraction bits. An all-zero
// input gives zero components and raises o_zero.
// ---------------------------------------------------------------------------
module qnl_norm #(
    parameter int V_W   = 16,
    parameter int PRE   = 14,
    parameter int F     = 14,
    parameter int PAY_W = 15
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [V_W-1:0]   i_v [qnl_pkg::QNL_LANES],
    input  logic [PAY_W-1:0]        i_pay,
    output logic                    o_valid,
    output logic signed [F+1:0]     o_n [qnl_pkg::QNL_LANES],
    output logic                    o_zero,
    output logic [PAY_W-1:0]        o_pay
);
    import qnl_pkg::*;

    localparam int M2_W  = 2 * V_W + 1;
    localparam int X_W   = M2_W + 2 * PRE;
    localparam int RAD_W = X_W + (X_W % 2);
    localparam int RT_W  = RAD_W / 2;
    localparam int SHIFT = F + PRE;
    localparam int NUM_W = ((V_W + SHIFT > RT_W) ? (V_W + SHIFT) : RT_W) + 1;
    localparam int Q_W   = F + 1;
    localparam int O_W   = F + 2;
    localparam int SP_W  = PAY_W + 1 + QNL_LANES * V_W;
    localparam int DP_W  = PAY_W + 2;

    // stage 1: absolute value and square per lane
    logic [2*V_W-1:0]      r1_sq [QNL_LANES];
    logic signed [V_W-1:0] r1_v  [QNL_LANES];
    logic [PAY_W-1:0]      r1_pay;
    logic                  r1_vld;
    logic [V_W-1:0]        w1_abs [QNL_LANES];

    always_comb begin
        for (int l = 0; l < QNL_LANES; l++) begin
            w1_abs[l] = i_v[l][V_W-1] ? (~i_v[l] + 1'b1) : i_v[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < QNL_LANES; l++) begin
                r1_sq[l] <= w1_abs[l] * w1_abs[l];
                r1_v[l]  <= i_v[l];
            end
            r1_pay <= i_pay;
        end
    end

    // stage 2: pairwise sums
    logic [M2_W-1:0]       r2_s01;
    logic [M2_W-1:0]       r2_s23;
    logic signed [V_W-1:0] r2_v [QNL_LANES];
    logic [PAY_W-1:0]      r2_pay;
    logic                  r2_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_s01 <= M2_W'(r1_sq[0]) + M2_W'(r1_sq[1]);
            r2_s23 <= M2_W'(r1_sq[2]) + M2_W'(r1_sq[3]);
            r2_v   <= r1_v;
            r2_pay <= r1_pay;
        end
    end

    // stage 3: squared magnitude
    logic [M2_W-1:0]       r3_m2;
    logic signed [V_W-1:0] r3_v [QNL_LANES];
    logic [PAY_W-1:0]      r3_pay;
    logic                  r3_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_m2  <= r2_s01 + r2_s23;
            r3_v   <= r2_v;
            r3_pay <= r2_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // square root of m2 scaled by 2^(2*PRE)
    logic [RAD_W-1:0] w3_rad;
    logic [SP_W-1:0]  w3_sp;
    logic             w_sq_vld;
    logic [RT_W-1:0]  w_mag;
    logic [SP_W-1:0]  w_sq_pay;

    assign w3_rad = RAD_W'(r3_m2) << (2 * PRE);

    always_comb begin
        w3_sp = '0;
        for (int l = 0; l < QNL_LANES; l++) begin
            w3_sp[l*V_W +: V_W] = r3_v[l];
        end
        w3_sp[QNL_LANES*V_W]        = (r3_m2 == '0);
        w3_sp[SP_W-1 -: PAY_W]      = r3_pay;
    end

    qnl_isqrt #(
        .IN_W  (RAD_W),
        .PAY_W (SP_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r3_vld),
        .i_rad   (w3_rad),
        .i_pay   (w3_sp),
        .o_valid (w_sq_vld),
        .o_root  (w_mag),
        .o_pay   (w_sq_pay)
    );

    // stage 4: rounded numerators |v| * 2^SHIFT + mag/2
    logic [NUM_W-1:0]  r4_num [QNL_LANES];
    logic [RT_W-1:0]   r4_den;
    logic [QNL_LANES-1:0] r4_sign;
    logic              r4_zero;
    logic [PAY_W-1:0]  r4_pay;
    logic              r4_vld;
    logic [V_W-1:0]    w4_v   [QNL_LANES];
    logic [V_W-1:0]    w4_abs [QNL_LANES];

    always_comb begin
        for (int l = 0; l < QNL_LANES; l++) begin
            w4_v[l]   = w_sq_pay[l*V_W +: V_W];
            w4_abs[l] = w4_v[l][V_W-1] ? (~w4_v[l] + 1'b1) : w4_v[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < QNL_LANES; l++) begin
                r4_num[l]  <= (NUM_W'(w4_abs[l]) << SHIFT) + NUM_W'(w_mag >> 1);
                r4_sign[l] <= w4_v[l][V_W-1];
            end
            r4_den  <= w_mag;
            r4_zero <= w_sq_pay[QNL_LANES*V_W];
            r4_pay  <= w_sq_pay[SP_W-1 -: PAY_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= w_sq_vld;
        end
    end

    // divider lanes, one per component
    logic [Q_W-1:0]       w_quo  [QNL_LANES];
    logic [DP_W-1:0]      w_dpay [QNL_LANES];
    logic [QNL_LANES-1:0] w_dvld;

    for (genvar l = 0; l < QNL_LANES; l++) begin : g_lane
        qnl_div #(
            .NUM_W (NUM_W),
            .DEN_W (RT_W),
            .Q_W   (Q_W),
            .PAY_W (DP_W)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (r4_vld),
            .i_num   (r4_num[l]),
            .i_den   (r4_den),
            .i_pay   ({r4_pay, r4_zero, r4_sign[l]}),
            .o_valid (w_dvld[l]),
            .o_quo   (w_quo[l]),
            .o_pay   (w_dpay[l])
        );
    end

    // stage 5: restore sign, force zero for a zero-length input
    logic signed [O_W-1:0] r5_n [QNL_LANES];
    logic                  r5_zero;
    logic [PAY_W-1:0]      r5_pay;
    logic                  r5_vld;
    logic signed [O_W-1:0] w5_q [QNL_LANES];

    always_comb begin
        for (int l = 0; l < QNL_LANES; l++) begin
            w5_q[l] = $signed({1'b0, w_quo[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < QNL_LANES; l++) begin
                if (w_dpay[0][1]) begin
                    r5_n[l] <= '0;
                end else if (w_dpay[l][0]) begin
                    r5_n[l] <= -w5_q[l];
                end else begin
                    r5_n[l] <= w5_q[l];
                end
            end
            r5_zero <= w_dpay[0][1];
            r5_pay  <= w_dpay[0][DP_W-1 -: PAY_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= w_dvld[0];
        end
    end

    assign o_valid = r5_vld;
    assign o_n     = r5_n;
    assign o_zero  = r5_zero;
    assign o_pay   = r5_pay;

    // all divider lanes carry the same request in lockstep
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dvld == '0) || (w_dvld == '1))
        else $error("qnl_norm: divider lanes out of step");

endmodule

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb - regression bench for quaternion_nlerp
// Drives quaternion pairs and blend factors over the input stream, predicts
// each normalized blend in fixed point and checks every output request in
// order. Covers directed corner cases, random traffic with and without
// idling, a long output hold-off and a drain pause.
// ---------------------------------------------------------------------------
module tb;

    localparam int FRAC_BITS  = 14;
    localparam int COMP_WIDTH = 16;
    localparam int IN_W       = ((8*COMP_WIDTH+FRAC_BITS+8)/8)*8;
    localparam int OUT_W      = ((4*COMP_WIDTH+7)/8)*8;
    localparam int LATENCY    = 2 * (31 + FRAC_BITS + 6) + 3;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        zero;
    } t_blend;

    logic              i_clk;
    logic              i_rst_n;
    logic [IN_W-1:0]   s_tdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;
    logic              m_tvalid;
    logic              m_tready;

    t_blend blend_q[$];
    int     err_cnt;
    bit     idle_on;
    bit     hold_req;
    int     hold_left;

    quaternion_nlerp #(
        .FRAC_BITS (FRAC_BITS),
        .COMP_WIDTH(COMP_WIDTH)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (s_tdata),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned mag_of(input longint unsigned v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // scale four two's complement lanes to unit length; 1 when all zero
    function automatic bit to_unit(input longint unsigned v[4], input int pre,
                                   output longint unsigned o[4]);
        longint unsigned m2;
        longint unsigned mg;
        longint unsigned q;
        m2 = 0;
        for (int i = 0; i < 4; i++) m2 += mag_of(v[i]) * mag_of(v[i]);
        if (m2 == 0) begin
            for (int i = 0; i < 4; i++) o[i] = v[i];
            return 1'b1;
        end
        mg = int_sqrt(m2 << (2 * pre));
        if (mg == 0) mg = 1;
        for (int i = 0; i < 4; i++) begin
            q = mag_of(v[i]) << (FRAC_BITS + pre);
            q = (q + mg / 2) / mg;
            o[i] = v[i][63] ? (64'd0 - q) : q;
        end
        return 1'b0;
    endfunction

    function automatic logic [15:0] clamp16(input longint unsigned v);
        if (v[63]) begin
            if (mag_of(v) > 64'd32768) return 16'h8000;
        end else if (v > 64'd32767) begin
            return 16'h7fff;
        end
        return v[15:0];
    endfunction

    // expected normalized blend for one request
    function automatic t_blend nlerp_of(input logic [IN_W-1:0] d);
        longint unsigned qa[4], qb[4], na[4], nb[4], r[4], o[4];
        longint unsigned t, om;
        longint          dot;
        bit              z;
        t_blend          e;
        for (int i = 0; i < 4; i++) begin
            qa[i] = longint'($signed(d[16*i +: 16]));
            qb[i] = longint'($signed(d[64 + 16*i +: 16]));
        end
        t = d[128 +: 15];
        if (t > 16384) t = 16384;
        om = 16384 - t;
        void'(to_unit(qa, FRAC_BITS, na));
        void'(to_unit(qb, FRAC_BITS, nb));
        dot = 0;
        for (int i = 0; i < 4; i++) dot += longint'(na[i]) * longint'(nb[i]);
        if (dot < 0)
            for (int i = 0; i < 4; i++) nb[i] = 64'd0 - nb[i];
        for (int i = 0; i < 4; i++) r[i] = na[i] * om + nb[i] * t;
        z = to_unit(r, 0, o);
        e.w    = z ? 16'd0 : clamp16(o[0]);
        e.x    = z ? 16'd0 : clamp16(o[1]);
        e.y    = z ? 16'd0 : clamp16(o[2]);
        e.z    = z ? 16'd0 : clamp16(o[3]);
        e.zero = z;
        return e;
    endfunction

    function automatic logic [IN_W-1:0] pair(
        input logic [15:0] aw, ax, ay, az, bw, bx, by, bz,
        input logic [14:0] t);
        return {1'b0, t, bz, by, bx, bw, az, ay, ax, aw};
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
        err_cnt++;
    endtask

    // send one request, idling first at random
    task automatic send(input logic [IN_W-1:0] d);
        while (idle_on && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        blend_q = {blend_q, nlerp_of(d)};
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (blend_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_comp(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(32768) - 16384);
            default: return 16'($urandom_range(8) - 4);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rnd_pair();
        logic [15:0] a[4], b[4];
        logic [14:0] t;
        int          mode;
        mode = int'($urandom_range(5));
        for (int i = 0; i < 4; i++) begin
            a[i] = rnd_comp(mode > 2 ? 1 : mode);
            b[i] = rnd_comp(mode > 2 ? 1 : mode);
        end
        // b copies a with the sign of each component flipped at random
        if (mode == 3)
            for (int i = 0; i < 4; i++) b[i] = $urandom_range(1) ? a[i] : -a[i];
        // one side zero
        if (mode == 4) begin
            for (int i = 0; i < 4; i++)
                if ($urandom_range(1)) a[i] = 16'd0; else b[i] = 16'd0;
            if ($urandom_range(1)) a = '{default: 16'd0};
            else b = '{default: 16'd0};
        end
        t = ($urandom_range(4) == 0) ? 15'($urandom) : 15'($urandom_range(16384));
        return pair(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3], t);
    endfunction

    // output side: random idling plus a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 600;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(idle_on && $urandom_range(99) < 9);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_blend e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (blend_q.size() == 0) begin
                report("unexpected result", m_tdata, 64'd0);
            end else begin
                e = blend_q.pop_front();
                if (m_tdata[15:0]  !== e.w) report("r_w", 64'(m_tdata[15:0]), 64'(e.w));
                if (m_tdata[31:16] !== e.x) report("r_x", 64'(m_tdata[31:16]), 64'(e.x));
                if (m_tdata[47:32] !== e.y) report("r_y", 64'(m_tdata[47:32]), 64'(e.y));
                if (m_tdata[63:48] !== e.z) report("r_z", 64'(m_tdata[63:48]), 64'(e.z));
                if (m_tuser !== e.zero)
                    report("zero_result", 64'(m_tuser), 64'(e.zero));
            end
        end
    end

    task automatic test_corners();
        // both zero, zero a with t zero, zero a, zero b
        send(pair(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd8192));
        send(pair(16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 15'd0));
        send(pair(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 15'd8192));
        send(pair(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd16384));
        // orthogonal pair, dot exactly zero
        send(pair(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0,
                  15'd8192));
        // opposite pair takes the short arc
        send(pair(16'd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0,
                  15'd8192));
        send(pair(16'sd100, -16'sd200, 16'sd300, -16'sd400,
                  -16'sd100, 16'sd200, -16'sd300, 16'sd400, 15'd4096));
        // blend ends and above one
        send(pair(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 15'd0));
        send(pair(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0,
                  15'd16384));
        send(pair(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384,
                  15'd16385));
        send(pair(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384,
                  15'h7fff));
        // component extremes
        send(pair(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 15'd8192));
        send(pair(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                  16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 15'd1));
        send(pair(16'h8000, 16'd0, 16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0, 16'd0,
                  15'd16383));
        send(pair(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hffff, 15'd8192));
        send(pair(16'd1, 16'd1, 16'd1, 16'd1, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  15'd12000));
        send(pair(16'hffff, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0));
        stop_sending();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send(rnd_pair());
        stop_sending();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 200; i++) send(rnd_pair());
        stop_sending();
    endtask

    task automatic test_pause();
        for (int i = 0; i < 40; i++) send(rnd_pair());
        stop_sending();
        drain();
        for (int i = 0; i < 40; i++) send(rnd_pair());
        stop_sending();
    endtask

    initial begin
        err_cnt   = 0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        hold_left = 0;
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        idle_on = 1'b0;
        test_random(600);
        idle_on = 1'b1;
        test_random(1050);
        test_backpressure();
        test_pause();

        drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("quaternion_nlerp regression: pass");
        else
            $display("quaternion_nlerp regression: fail");
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("quaternion_nlerp regression: fail");
        $finish;
    end

endmodule
